>>> rtl/core/rgbcx_pkg.sv
package rgbcx_pkg;

  typedef logic [23:0] pix_t;

  localparam logic [1:0] MODE_BLUR    = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;
  localparam logic [1:0] MODE_TRIM    = 2'd2;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  localparam logic [10:0] SIZE_RESET = 11'd1024;
  localparam int unsigned MIN_SIZE = 3;

  // Reciprocals scaled by 2^16, exact for the sums that can occur.
  localparam logic [13:0] RECIP_9 = 14'd7282;
  localparam logic [13:0] RECIP_7 = 14'd9363;

  typedef struct packed {
    logic emit;
    logic filt;
    logic last;
  } ctl_t;

endpackage

>>> rtl/core/rgbcx_ram.sv
module rgbcx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/rgb_conv3x3_extremum_filter.sv
// 3x3 RGB window filter for a square image streamed in raster order.
// Input channel: one pixel per item (in_red_in, in_green_in, in_blue_in),
// or a flush item that carries no pixel. After the last pixel of a frame,
// image_size+1 flush items drain the outputs still pending. A flush that
// arrives earlier is taken and dropped.
// Output channel: one pixel per item; out_last_of_frame marks the last
// pixel of the frame, after which the block is ready for the next frame.
// Each output follows its input by one row plus one pixel of the stream,
// and between acceptance and out_valid it passes the s1, s2, s3 and
// output registers. Throughput is one item per cycle while no output
// is stalled: each line store is a single RAM read and written once per
// item, with forwarding when successive items hit the same column.
// Configuration: cfg_index 0 selects the mode, 1 the image size. Writes
// are taken at any time but are meant for an idle block.
// Reset clears the position counters, window and pipeline; mode returns
// to blur and the size to 1024. While out_stall holds a waiting item the
// whole pipeline freezes and in_stall is raised.
module rgb_conv3x3_extremum_filter #(
  parameter int MAX_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_flush,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import rgbcx_pkg::*;

  localparam int CW = $clog2(MAX_SIZE + 3);
  localparam int EW = 2 * CW;
  localparam int AW = $clog2(MAX_SIZE);
  localparam int SIZE_RST = (MAX_SIZE < 1024) ? MAX_SIZE : 1024;

  logic [1:0]    mode_r;
  logic [CW-1:0] s_r, s_nxt;
  logic [EW-1:0] sq_r;

  logic [CW-1:0] col_r, row_r;
  logic [EW-1:0] cnt_r;

  logic en;
  logic wrap0, wrap1, drain, ignore, acc, act, emit, filt, last;
  logic [CW-1:0] x0, y0, x1, xn, yn;
  pix_t px;

  logic          s1_v_r, s1_fwd_r;
  logic [AW-1:0] s1_addr_r;
  pix_t          s1_px_r, fwd_a_r, fwd_b_r;
  ctl_t          s1_ctl_r;
  pix_t          rd_a, rd_b, top, mid;

  pix_t win_r [9];
  logic s2_v_r;
  ctl_t s2_ctl_r;

  logic       s3_v_r;
  ctl_t       s3_ctl_r;
  logic [11:0] s3_sum_r [3];
  pix_t       s3_ctr_r, s3_lo_r, s3_hi_r;

  logic [11:0] sum_c [3];
  logic [9:0]  inten [9];
  logic [9:0]  lo_i, hi_i;
  pix_t        lo_px, hi_px;

  logic        out_v_r, out_last_r;
  logic [7:0]  out_ch_r [3];
  logic [7:0]  res_ch [3];

  assign en        = !(out_v_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Configuration.
  always_comb begin
    if (32'(cfg_data) < MIN_SIZE) begin
      s_nxt = CW'(MIN_SIZE);
    end else if (32'(cfg_data) > 32'(MAX_SIZE)) begin
      s_nxt = CW'(MAX_SIZE);
    end else begin
      s_nxt = CW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BLUR;
      s_r    <= CW'(SIZE_RST);
      sq_r   <= EW'(SIZE_RST * SIZE_RST);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE: mode_r <= cfg_data[1:0];
          CFG_SIZE: begin
            s_r  <= s_nxt;
            sq_r <= EW'(s_nxt) * EW'(s_nxt);
          end
          default:  mode_r <= mode_r;
        endcase
      end
    end
  end

  // Position tracking at acceptance.
  always_comb begin
    wrap0  = col_r >= s_r;
    x0     = wrap0 ? '0 : col_r;
    y0     = wrap0 ? row_r + 1'b1 : row_r;
    drain  = y0 >= s_r;
    ignore = !drain && in_flush;
    acc    = in_valid && en;
    act    = acc && !ignore;
    emit   = drain || (y0 >= CW'(2)) || (y0 == CW'(1) && x0 >= CW'(1));
    x1     = x0 + 1'b1;
    wrap1  = x1 >= s_r;
    xn     = wrap1 ? '0 : x1;
    yn     = wrap1 ? y0 + 1'b1 : y0;
    filt   = !drain && (yn >= CW'(2)) && (xn >= CW'(3) || xn == '0) && (mode_r <= MODE_TRIM);
    last   = emit && ((cnt_r + 1'b1) >= sq_r);
    px     = drain ? '0 : {in_red_in, in_green_in, in_blue_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
    end else if (act) begin
      if (last) begin
        col_r <= '0;
        row_r <= '0;
        cnt_r <= '0;
      end else begin
        col_r <= xn;
        row_r <= yn;
        if (emit) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Line stores.
  assign top = s1_fwd_r ? fwd_a_r : rd_a;
  assign mid = s1_fwd_r ? fwd_b_r : rd_b;

  rgbcx_ram #(.WIDTH(24), .DEPTH(MAX_SIZE)) u_line_a (
    .clk   (clk),
    .we    (en && s1_v_r),
    .waddr (s1_addr_r),
    .wdata (mid),
    .re    (act),
    .raddr (x0[AW-1:0]),
    .rdata (rd_a)
  );

  rgbcx_ram #(.WIDTH(24), .DEPTH(MAX_SIZE)) u_line_b (
    .clk   (clk),
    .we    (en && s1_v_r),
    .waddr (s1_addr_r),
    .wdata (s1_px_r),
    .re    (act),
    .raddr (x0[AW-1:0]),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (en && act) begin
      s1_addr_r <= x0[AW-1:0];
      s1_px_r   <= px;
      s1_ctl_r  <= '{emit: emit, filt: filt, last: last};
      s1_fwd_r  <= s1_v_r && (s1_addr_r == x0[AW-1:0]);
    end
    if (en && s1_v_r) begin
      fwd_a_r <= mid;
      fwd_b_r <= s1_px_r;
    end
  end

  // Window shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r && s1_ctl_r.emit;
      if (s1_v_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= top;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= mid;
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // Sums and extreme-intensity pixels.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = '0;
      for (int i = 0; i < 9; i++) begin
        sum_c[c] = sum_c[c] + 12'(win_r[i][16-8*c +: 8]);
      end
    end
    for (int i = 0; i < 9; i++) begin
      inten[i] = 10'(win_r[i][23:16]) + 10'(win_r[i][15:8]) + 10'(win_r[i][7:0]);
    end
    lo_i  = inten[0];
    hi_i  = inten[0];
    lo_px = win_r[0];
    hi_px = win_r[0];
    for (int i = 1; i < 9; i++) begin
      if (inten[i] <= lo_i) begin
        lo_i  = inten[i];
        lo_px = win_r[i];
      end
      if (inten[i] > hi_i) begin
        hi_i  = inten[i];
        hi_px = win_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_v_r) begin
      s3_ctl_r <= s2_ctl_r;
      s3_sum_r <= sum_c;
      s3_ctr_r <= win_r[4];
      s3_lo_r  <= lo_px;
      s3_hi_r  <= hi_px;
    end
  end

  // Per-channel arithmetic and clamp.
  always_comb begin
    logic [7:0]         ctr;
    logic [11:0]        trim;
    logic [25:0]        prod;
    logic [11:0]        ten;
    logic signed [13:0] sv;
    for (int c = 0; c < 3; c++) begin
      ctr  = s3_ctr_r[16-8*c +: 8];
      trim = s3_sum_r[c] - 12'(s3_lo_r[16-8*c +: 8]) - 12'(s3_hi_r[16-8*c +: 8]);
      ten  = 12'(ctr) * 12'd10;
      sv   = $signed({2'b00, ten}) - $signed({2'b00, s3_sum_r[c]});
      prod = '0;
      res_ch[c] = ctr;
      if (s3_ctl_r.filt) begin
        case (mode_r)
          MODE_BLUR: begin
            prod      = 26'(s3_sum_r[c]) * 26'(RECIP_9);
            res_ch[c] = prod[23:16];
          end
          MODE_SHARPEN: begin
            if (sv < 0) begin
              res_ch[c] = 8'd0;
            end else if (sv > 14'sd255) begin
              res_ch[c] = 8'd255;
            end else begin
              res_ch[c] = sv[7:0];
            end
          end
          MODE_TRIM: begin
            prod      = 26'(trim) * 26'(RECIP_7);
            res_ch[c] = prod[23:16];
          end
          default: res_ch[c] = ctr;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_v_r) begin
      out_ch_r   <= res_ch;
      out_last_r <= s3_ctl_r.last;
    end
  end

  assign out_valid         = out_v_r;
  assign out_red_out       = out_ch_r[0];
  assign out_green_out     = out_ch_r[1];
  assign out_blue_out      = out_ch_r[2];
  assign out_last_of_frame = out_last_r;

`ifndef SYNTHESIS
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_ch_r[0]) && $stable(out_last_r))
    else $error("output changed while stalled");
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !en |=> s3_v_r)
    else $error("pipeline item lost during stall");
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    en && act && s1_v_r && (s1_addr_r == x0[AW-1:0]) |=> s1_fwd_r)
    else $error("line store forwarding missed");
`endif

endmodule

>>> tb/sv/tb_rgb_conv3x3_extremum_filter.sv
`timescale 1ns / 1ps

module tb_rgb_conv3x3_extremum_filter;
  import rgbcx_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } out_pixel_t;

  class frame_scoreboard;
    pix_t        row_a [1024];
    pix_t        row_b [1024];
    pix_t        win [9];
    int unsigned col;
    int unsigned row;
    int unsigned emitted;
    logic [1:0]  mode;
    logic [10:0] size;
    out_pixel_t  pending [$];
    int          errors;
    int          mismatches;
    int          pixels_checked;
    int          frames_seen;

    function new();
      foreach (row_a[i]) begin
        row_a[i] = '0;
        row_b[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      emitted = 0;
      mode = MODE_BLUR;
      size = SIZE_RESET;
      errors = 0;
      mismatches = 0;
      pixels_checked = 0;
      frames_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [10:0] data);
      if (idx == CFG_MODE) mode = data[1:0];
      else size = data;
    endfunction

    function int unsigned side();
      int unsigned s;
      s = size;
      if (s < MIN_SIZE) s = MIN_SIZE;
      if (s > 1024) s = 1024;
      return s;
    endfunction

    function int chan(pix_t px, int c);
      return int'(px[16 - 8 * c +: 8]);
    endfunction

    function logic [7:0] clamp(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function pix_t filter_window();
      pix_t res;
      int lo, hi, lo_i, hi_i, t, sum, v;
      lo = 0;
      hi = 0;
      lo_i = 766;
      hi_i = -1;
      for (int i = 0; i < 9; i++) begin
        t = chan(win[i], 0) + chan(win[i], 1) + chan(win[i], 2);
        if (t <= lo_i) begin
          lo_i = t;
          lo = i;
        end
        if (t > hi_i) begin
          hi_i = t;
          hi = i;
        end
      end
      for (int c = 0; c < 3; c++) begin
        sum = 0;
        for (int i = 0; i < 9; i++) sum += chan(win[i], c);
        if (mode == MODE_BLUR) v = sum / 9;
        else if (mode == MODE_SHARPEN) v = 10 * chan(win[4], c) - sum;
        else v = (sum - chan(win[lo], c) - chan(win[hi], c)) / 7;
        res[16 - 8 * c +: 8] = clamp(v);
      end
      return res;
    endfunction

    function void note_item(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
      int unsigned s, x, y;
      pix_t newpx, centre, res;
      bit drain, emit;
      out_pixel_t o;
      s = side();
      x = col;
      y = row;
      if (x >= s) begin
        x = 0;
        y++;
      end
      drain = (y >= s);
      if (!drain && fl) return;
      newpx = drain ? 24'd0 : {r, g, b};
      for (int k = 0; k < 3; k++) begin
        win[k * 3] = win[k * 3 + 1];
        win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = row_a[x];
      win[5] = row_b[x];
      win[8] = newpx;
      row_a[x] = row_b[x];
      row_b[x] = newpx;
      emit = drain || y >= 2 || (y == 1 && x >= 1);
      centre = win[4];
      x++;
      if (x >= s) begin
        x = 0;
        y++;
      end
      col = x;
      row = y;
      if (!emit) return;
      if (!drain && row > 0 && y >= 2 && (x >= 3 || x == 0) && mode <= MODE_TRIM)
        res = filter_window();
      else
        res = centre;
      o.red = res[23:16];
      o.green = res[15:8];
      o.blue = res[7:0];
      if (emitted + 1 >= s * s) begin
        o.last = 1'b1;
        row = 0;
        col = 0;
        emitted = 0;
      end else begin
        o.last = 1'b0;
        emitted++;
      end
      pending.push_back(o);
    endfunction

    function void check_pixel(out_pixel_t got);
      out_pixel_t exp_px;
      pixels_checked++;
      if (got.last) frames_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected output pixel %h %h %h last %b",
                                   got.red, got.green, got.blue, got.last);
        return;
      end
      exp_px = pending.pop_front();
      if (got !== exp_px) begin
        errors++;
        mismatches++;
        if (errors <= 10)
          $display("Pixel mismatch: expected %h %h %h last %b, got %h %h %h last %b",
                   exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                   got.red, got.green, got.blue, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_red_in;
  logic [7:0]  in_green_in;
  logic [7:0]  in_blue_in;
  logic        in_flush;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_last_of_frame;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [10:0] cfg_data;

  frame_scoreboard sb;
  int  items_taken;
  int  cycles;
  bit  quiet;
  int  stall_left;
  int  frames_sent;
  bit  running;

  rgb_conv3x3_extremum_filter dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      sb.note_item(in_red_in, in_green_in, in_blue_in, in_flush);
      items_taken++;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel('{out_red_out, out_green_out, out_blue_out, out_last_of_frame});
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      stall_left = running ? pick_gap() : 0;
      out_stall = (stall_left > 0);
    end
  end

  task automatic send_item(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
    int gap;
    int target;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    target = items_taken + 1;
    in_red_in = r;
    in_green_in = g;
    in_blue_in = b;
    in_flush = fl;
    in_valid = 1'b1;
    do @(negedge clk); while (items_taken < target);
  endtask

  task automatic write_reg(logic idx, logic [10:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function logic [7:0] rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_frame(int unsigned s);
    for (int i = 0; i < s * s; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(rand_chan(), rand_chan(), rand_chan(), 1'b1);
      send_item(rand_chan(), rand_chan(), rand_chan(), 1'b0);
    end
    for (int i = 0; i <= s; i++)
      send_item(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 4) != 0);
    frames_sent++;
  endtask

  initial begin
    int unsigned s;
    logic [10:0] size_reg;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    in_flush = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    items_taken = 0;
    cycles = 0;
    quiet = 1'b0;
    stall_left = 0;
    frames_sent = 0;
    running = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(CFG_SIZE, 11'd2047);
    write_reg(CFG_SIZE, 11'd1024);
    write_reg(CFG_MODE, 11'(MODE_SHARPEN));
    write_reg(CFG_SIZE, 11'd3);
    running = 1'b1;
    send_item(8'd12, 8'd34, 8'd56, 1'b1);
    send_item(8'd255, 8'd255, 8'd255, 1'b0);
    send_item(8'd0, 8'd0, 8'd0, 1'b0);
    send_item(8'd255, 8'd0, 8'd255, 1'b0);
    send_item(8'd0, 8'd255, 8'd0, 1'b0);
    send_item(8'd0, 8'd0, 8'd0, 1'b1);
    send_item(8'd255, 8'd255, 8'd255, 1'b0);
    send_item(8'd0, 8'd0, 8'd0, 1'b0);
    send_item(8'd128, 8'd1, 8'd254, 1'b0);
    send_item(8'd255, 8'd255, 8'd255, 1'b0);
    send_item(8'd0, 8'd0, 8'd0, 1'b0);
    send_item(8'd0, 8'd0, 8'd0, 1'b1);
    send_item(8'd170, 8'd85, 8'd170, 1'b0);
    send_item(8'd0, 8'd0, 8'd0, 1'b1);
    send_item(8'd0, 8'd0, 8'd0, 1'b1);
    frames_sent++;
    wait_idle();

    while (items_taken < 1350) begin
      quiet = ($urandom_range(0, 4) == 0);
      write_reg(CFG_MODE, 11'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        0: size_reg = 11'($urandom_range(0, 2));
        1: size_reg = 11'd20;
        default: size_reg = 11'($urandom_range(3, 8));
      endcase
      write_reg(CFG_SIZE, size_reg);
      s = sb.side();
      random_frame(s);
      wait_idle();
    end
    running = 1'b0;
    repeat (20) @(negedge clk);

    $display("Sent %0d frames in %0d items over all modes and sizes 3 to 20;",
             frames_sent, items_taken);
    $display("checked %0d output pixels and %0d frame ends.", sb.pixels_checked,
             sb.frames_seen);
    if (sb.errors > 10) $display("%0d further errors not shown.", sb.errors - 10);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0d expected pixels never arrived.", sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rgbcx_pkg.sv
rtl/core/rgbcx_ram.sv
rtl/core/rgb_conv3x3_extremum_filter.sv
tb/sv/tb_rgb_conv3x3_extremum_filter.sv
